FILE: src/crc8fd_pkg.sv
// Package with shared types, codes and the CRC-8 update function of the frame deframer.
`timescale 1ns / 1ps
`default_nettype none

package crc8fd_pkg;

  localparam logic [7:0] SYNC_BYTE_RESET     = 8'hAA;
  localparam logic [7:0] MAX_FRAME_LEN_RESET = 8'hFF;
  localparam logic [7:0] MIN_FRAME_LEN       = 8'd4;
  localparam logic [7:0] CRC_POLY            = 8'h07;

  // Configuration register indexes.
  localparam logic [1:0] REG_SYNC_BYTE     = 2'd0;
  localparam logic [1:0] REG_MAX_FRAME_LEN = 2'd1;

  // Deframer phase codes; the unused code behaves as hunting.
  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;

  typedef struct packed {
    logic [7:0] sync_byte;
    logic [7:0] max_frame_len;
  } cfg_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic [7:0] byte_index;
    logic       in_frame;
    logic       frame_end;
    logic       crc_ok;
    logic       size_error;
  } result_t;

  // One byte of CRC-8, MSB first, no reflection.
  function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: src/crc8fd_cfg.sv
// Configuration register file of the frame deframer.
`timescale 1ns / 1ps
`default_nettype none

module crc8fd_cfg
  import crc8fd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  output cfg_t            cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_byte     <= SYNC_BYTE_RESET;
      cfg.max_frame_len <= MAX_FRAME_LEN_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SYNC_BYTE:     cfg.sync_byte     <= cfg_data;
        REG_MAX_FRAME_LEN: cfg.max_frame_len <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: src/crc8fd_fsm.sv
// Frame state and per-byte decode logic of the frame deframer.
`timescale 1ns / 1ps
`default_nettype none

module crc8fd_fsm
  import crc8fd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [7:0] data_byte,
  input  wire cfg_t       cfg,
  output result_t         result
);

  logic [1:0] phase, phase_next;
  logic [7:0] byte_count, byte_count_next;
  logic [7:0] frame_length, frame_length_next;
  logic [7:0] running_crc, running_crc_next;
  logic [7:0] crc_step;
  logic [8:0] count_plus;

  // The running CRC seeds from zero on a start byte, so one update unit serves all phases.
  assign crc_step   = crc_update((phase == PH_LEN || phase == PH_BODY) ? running_crc : 8'd0,
                                 data_byte);
  assign count_plus = {1'b0, byte_count} + 9'd1;

  always_comb begin
    phase_next        = PH_HUNT;
    byte_count_next   = 8'd0;
    frame_length_next = 8'd0;
    running_crc_next  = 8'd0;
    result            = '0;
    result.byte_out   = data_byte;
    unique case (phase)
      PH_LEN: begin
        result.in_frame   = 1'b1;
        result.byte_index = 8'd1;
        if (data_byte < MIN_FRAME_LEN || data_byte > cfg.max_frame_len) begin
          result.size_error = 1'b1;
        end else begin
          phase_next        = PH_BODY;
          byte_count_next   = 8'd2;
          frame_length_next = data_byte;
          running_crc_next  = crc_step;
        end
      end
      PH_BODY: begin
        result.in_frame   = 1'b1;
        result.byte_index = byte_count;
        if (count_plus >= {1'b0, frame_length}) begin
          result.frame_end = 1'b1;
          result.crc_ok    = (data_byte == running_crc);
        end else begin
          phase_next        = PH_BODY;
          byte_count_next   = count_plus[7:0];
          frame_length_next = frame_length;
          running_crc_next  = crc_step;
        end
      end
      default: begin
        if (data_byte == cfg.sync_byte) begin
          result.in_frame  = 1'b1;
          phase_next       = PH_LEN;
          byte_count_next  = 8'd1;
          running_crc_next = crc_step;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      byte_count   <= 8'd0;
      frame_length <= 8'd0;
      running_crc  <= 8'd0;
    end else if (step) begin
      phase        <= phase_next;
      byte_count   <= byte_count_next;
      frame_length <= frame_length_next;
      running_crc  <= running_crc_next;
    end
  end

endmodule

`default_nettype wire

FILE: src/crc8_frame_deframer_unit.sv
// Top level of the CRC-8 length-prefixed frame deframer.
//
//   Channel   Signals                                   Direction  Moves
//   input     in_valid, in_stall, data_byte             in         one received byte
//   output    out_valid, out_stall, byte_out ...        out        one decoded byte
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data in         one register write
//
// Each accepted byte is captured in an input register. Once the result register is
// empty or draining, the frame logic decodes it against the current frame state,
// updates that state and loads the result register; one byte per cycle is sustained
// while out_stall is low. The single path that sets the cycle is the unrolled 8-bit CRC update plus length compare.
// Reset clears both valid flags, the frame state (hunting) and the configuration
// registers to their defaults. When the output is stalled with a result waiting, the
// input register still takes one more byte; in_stall rises only when both are full.
`timescale 1ns / 1ps
`default_nettype none

module crc8_frame_deframer_unit
  import crc8fd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  // Input byte channel.
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] data_byte,
  // Result channel.
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      byte_out,
  output logic [7:0]      byte_index,
  output logic            in_frame,
  output logic            frame_end,
  output logic            crc_ok,
  output logic            size_error,
  // Configuration write channel.
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  cfg_t       cfg;
  result_t    result;
  result_t    out_reg;
  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       advance;

  crc8fd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // A held byte moves on whenever the result register is empty or being drained.
  assign advance  = hold_valid && (!out_valid || !out_stall);
  assign in_stall = hold_valid && !advance;

  crc8fd_fsm u_fsm (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .data_byte (hold_byte),
    .cfg       (cfg),
    .result    (result)
  );

  // Input register: refills in the same cycle that its item moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold_byte <= data_byte;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_reg <= result;
    end
  end

  assign byte_out   = out_reg.byte_out;
  assign byte_index = out_reg.byte_index;
  assign in_frame   = out_reg.in_frame;
  assign frame_end  = out_reg.frame_end;
  assign crc_ok     = out_reg.crc_ok;
  assign size_error = out_reg.size_error;

endmodule

`default_nettype wire
